// ===== rtl/core/mcqd_pkg.sv =====
// Shared types and constants for the multi-channel quadrature decoder.
// No dependencies; imported by the decoder top level.
`default_nettype none
package mcqd_pkg;

	// Command codes of an input item.
	localparam logic [2:0] CMD_SAMPLE = 3'd0;
	localparam logic [2:0] CMD_ENABLE = 3'd1;
	localparam logic [2:0] CMD_DISABLE = 3'd2;
	localparam logic [2:0] CMD_CONFIG = 3'd3;
	localparam logic [2:0] CMD_SET = 3'd4;
	localparam logic [2:0] CMD_CHAN_EN = 3'd5;
	localparam logic [2:0] CMD_READ = 3'd6;

	// Event codes of a result item.
	localparam logic [2:0] EV_CW = 3'd0;
	localparam logic [2:0] EV_CCW = 3'd1;
	localparam logic [2:0] EV_BTN_DOWN = 3'd2;
	localparam logic [2:0] EV_BTN_UP = 3'd3;
	localparam logic [2:0] EV_READ = 3'd4;

	// Direction codes from the transition table.
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_PLUS = 2'd1;
	localparam logic [1:0] DIR_MINUS = 2'd2;

	localparam logic [15:0] SAMPLE_RESET = 16'hFFFF;
	localparam logic [1:0] QUAD_RESET = 2'b11;

	typedef struct packed {
		logic [2:0] command;
		logic [15:0] gpio;
		logic [2:0] channel;
		logic signed [31:0] min_value;
		logic signed [31:0] max_value;
		logic signed [31:0] step_size;
		logic signed [31:0] value;
		logic flag;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0] channel_out;
		logic [2:0] event_res;
		logic signed [31:0] position;
		logic button_state;
		logic pressed_flag;
		logic [31:0] update_count;
		logic last;
	} res_item_t;

	// 4x transition table indexed by {old pair, new pair}.
	function automatic logic [1:0] quad_dir(input logic [3:0] idx);
		logic [1:0] d;
		case (idx)
			4'd2, 4'd4, 4'd11, 4'd13: d = DIR_PLUS;
			4'd1, 4'd7, 4'd8, 4'd14: d = DIR_MINUS;
			default: d = DIR_NONE;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/multi_channel_quadrature_decoder.sv =====
// Multi-channel quadrature decoder: command decode, channel walk with one shared
// adder and clamp, and a result output register. Depends on mcqd_pkg.
//
//  channel | direction | handshake           | payload
//  cmd     | in        | cmd_valid/cmd_stall | cmd_item (mcqd_pkg::cmd_item_t)
//  res     | out       | res_valid/res_stall | res_item (mcqd_pkg::res_item_t)
//
// An item is accepted and then dispatched. A changed sample on an enabled block then
// walks the channels over the shared adder and clamp: a disabled channel takes only
// the add state, the others add and switch, or with rotation add, clamp and switch,
// and a flush follows. A set takes a clamp and a flush, a read a flush.
// Results wait in a one-entry hold stage so the final one can carry last; a
// stalled output pauses the walk. Reset (arst_n low) restores all channel state.
`default_nettype none
module multi_channel_quadrature_decoder #(
	parameter int CHANNELS = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_stall,
	input wire mcqd_pkg::cmd_item_t cmd_item,
	output logic res_valid,
	input wire logic res_stall,
	output mcqd_pkg::res_item_t res_item
);
	import mcqd_pkg::*;

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [2:0] LAST_CH = 3'(CHANNELS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_ADD = 3'd2;
	localparam logic [2:0] ST_CLAMP = 3'd3;
	localparam logic [2:0] ST_BTN = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;

	logic [2:0] state_q;
	cmd_item_t cmd_q;
	logic [2:0] ch_q;
	logic set_q;
	logic [1:0] dir_q;
	logic signed [33:0] sum_q;

	logic signed [31:0] pos_q [CHANNELS];
	logic signed [31:0] lo_q [CHANNELS];
	logic signed [31:0] hi_q [CHANNELS];
	logic signed [31:0] step_q [CHANNELS];
	logic [1:0] quad_q [CHANNELS];
	logic btn_q [CHANNELS];
	logic chg_q [CHANNELS];
	logic chen_q [CHANNELS];
	logic blk_en_q;
	logic [15:0] prev_q;
	logic [31:0] cnt_q;

	res_item_t pend_q;
	logic pend_valid_q;
	res_item_t out_q;
	logic out_valid_q;

	logic [IW-1:0] idx;
	logic ch_ok;
	logic [2:0] trip;
	logic [1:0] new_quad;
	logic [1:0] dir;
	logic signed [33:0] add_a;
	logic signed [33:0] add_b;
	logic signed [33:0] add_sum;
	logic signed [33:0] lo_ext;
	logic signed [33:0] hi_ext;
	logic signed [31:0] clamped;
	logic out_free;
	logic can_gen;
	logic push_v;
	res_item_t push_d;
	logic sw_pressed;
	logic read_pr;

	// Channel addressing and pin extraction; the clock pin is the high bit of the pair.
	always_comb begin
		idx = ch_q[IW-1:0];
		ch_ok = (32'(ch_q) < CHANNELS);
		trip = cmd_q.gpio[3*ch_q +: 3];
		new_quad = {trip[0], trip[1]};
		dir = quad_dir({quad_q[idx], new_quad});
		sw_pressed = ~trip[2];
		read_pr = chg_q[idx] & btn_q[idx];
	end

	// Shared adder: position plus signed step, or a raw value for set.
	always_comb begin
		if (cmd_q.command == CMD_SET) begin
			add_a = 34'(cmd_q.value);
			add_b = '0;
		end else begin
			add_a = 34'(pos_q[idx]);
			add_b = (dir == DIR_PLUS) ? 34'(step_q[idx]) : -34'(step_q[idx]);
		end
		add_sum = add_a + add_b;
	end

	// Shared clamp: lower bound is tested first.
	always_comb begin
		lo_ext = 34'(lo_q[idx]);
		hi_ext = 34'(hi_q[idx]);
		if (sum_q < lo_ext) begin
			clamped = lo_q[idx];
		end else if (sum_q > hi_ext) begin
			clamped = hi_q[idx];
		end else begin
			clamped = sum_q[31:0];
		end
	end

	assign out_free = !out_valid_q || !res_stall;
	assign can_gen = !pend_valid_q || out_free;

	// Hold stage drains to the output register when a newer result arrives or at the end.
	always_comb begin
		push_v = 1'b0;
		push_d = pend_q;
		push_d.last = 1'b0;
		if (state_q == ST_CLAMP && !set_q && can_gen) begin
			push_v = pend_valid_q;
		end else if (state_q == ST_BTN && sw_pressed != btn_q[idx] && can_gen) begin
			push_v = pend_valid_q;
		end else if (state_q == ST_FLUSH && pend_valid_q && out_free) begin
			push_v = 1'b1;
			push_d.last = 1'b1;
		end
	end

	// Sequencer and channel state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_valid_q <= 1'b0;
			blk_en_q <= 1'b0;
			prev_q <= SAMPLE_RESET;
			cnt_q <= '0;
			ch_q <= '0;
			set_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i] <= '0;
				lo_q[i] <= 32'sh8000_0000;
				hi_q[i] <= 32'sh7FFF_FFFF;
				step_q[i] <= 32'sd1;
				quad_q[i] <= QUAD_RESET;
				btn_q[i] <= 1'b0;
				chg_q[i] <= 1'b0;
				chen_q[i] <= 1'b1;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd_item;
						ch_q <= cmd_item.channel;
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					case (cmd_q.command)
						CMD_SAMPLE: begin
							if (blk_en_q && cmd_q.gpio != prev_q) begin
								cnt_q <= cnt_q + 32'd1;
								prev_q <= cmd_q.gpio;
								ch_q <= '0;
								state_q <= ST_ADD;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						CMD_ENABLE: begin
							if (!blk_en_q) begin
								prev_q <= cmd_q.gpio;
								blk_en_q <= 1'b1;
								for (int i = 0; i < CHANNELS; i++) begin
									quad_q[i] <= {cmd_q.gpio[3*i], cmd_q.gpio[3*i+1]};
									btn_q[i] <= ~cmd_q.gpio[3*i+2];
								end
							end
							state_q <= ST_IDLE;
						end
						CMD_DISABLE: begin
							blk_en_q <= 1'b0;
							state_q <= ST_IDLE;
						end
						CMD_CONFIG: begin
							if (ch_ok) begin
								lo_q[idx] <= cmd_q.min_value;
								hi_q[idx] <= cmd_q.max_value;
								step_q[idx] <= cmd_q.step_size;
								pos_q[idx] <= cmd_q.value;
							end
							state_q <= ST_IDLE;
						end
						CMD_SET: begin
							if (ch_ok) begin
								sum_q <= add_sum;
								set_q <= 1'b1;
								state_q <= ST_CLAMP;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						CMD_CHAN_EN: begin
							if (ch_ok) chen_q[idx] <= cmd_q.flag;
							state_q <= ST_IDLE;
						end
						CMD_READ: begin
							pend_q.channel_out <= ch_q;
							pend_q.event_res <= EV_READ;
							pend_q.update_count <= cnt_q;
							pend_q.last <= 1'b0;
							if (ch_ok) begin
								pend_q.position <= pos_q[idx];
								pend_q.button_state <= btn_q[idx];
								pend_q.pressed_flag <= read_pr;
								if (read_pr) chg_q[idx] <= 1'b0;
							end else begin
								pend_q.position <= '0;
								pend_q.button_state <= 1'b0;
								pend_q.pressed_flag <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							state_q <= ST_FLUSH;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_ADD: begin
					if (!chen_q[idx]) begin
						if (ch_q == LAST_CH) begin
							state_q <= ST_FLUSH;
						end else begin
							ch_q <= ch_q + 3'd1;
						end
					end else begin
						quad_q[idx] <= new_quad;
						dir_q <= dir;
						sum_q <= add_sum;
						state_q <= (dir == DIR_NONE) ? ST_BTN : ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					if (set_q) begin
						pos_q[idx] <= clamped;
						set_q <= 1'b0;
						state_q <= ST_FLUSH;
					end else if (can_gen) begin
						pos_q[idx] <= clamped;
						pend_q.channel_out <= ch_q;
						pend_q.event_res <= (dir_q == DIR_PLUS) ? EV_CW : EV_CCW;
						pend_q.position <= clamped;
						pend_q.button_state <= btn_q[idx];
						pend_q.pressed_flag <= 1'b0;
						pend_q.update_count <= cnt_q;
						pend_q.last <= 1'b0;
						pend_valid_q <= 1'b1;
						state_q <= ST_BTN;
					end
				end
				ST_BTN: begin
					if (sw_pressed == btn_q[idx] || can_gen) begin
						if (sw_pressed != btn_q[idx]) begin
							btn_q[idx] <= sw_pressed;
							chg_q[idx] <= 1'b1;
							pend_q.channel_out <= ch_q;
							pend_q.event_res <= sw_pressed ? EV_BTN_DOWN : EV_BTN_UP;
							pend_q.position <= pos_q[idx];
							pend_q.button_state <= sw_pressed;
							pend_q.pressed_flag <= 1'b0;
							pend_q.update_count <= cnt_q;
							pend_q.last <= 1'b0;
							pend_valid_q <= 1'b1;
						end
						if (ch_q == LAST_CH) begin
							state_q <= ST_FLUSH;
						end else begin
							ch_q <= ch_q + 3'd1;
							state_q <= ST_ADD;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= push_v;
			if (push_v) out_q <= push_d;
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = out_valid_q;
	assign res_item = out_q;

	// Checks on the sequencer and hold stage.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("hold stage not drained at idle");
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push_v |-> out_free)
		else $error("push into a full output register");
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD || state_q == ST_BTN) |-> ch_ok)
		else $error("channel walk out of range");
	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (state_q == ST_DISP))
		else $error("accepted item not dispatched");

endmodule
`default_nettype wire
